### hdl/dtmf_pkg.sv
`timescale 1ns / 1ps

package dtmf_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int AMP_W       = 15;
    localparam int HZ_W        = 11;
    localparam int DIGIT_W     = 4;
    localparam int RATE_W      = 17;
    localparam int POWER_W     = 7;
    localparam int DUR_W       = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_DIGIT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RATE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_POWER = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TONE  = 3'd4;

    localparam logic [DIGIT_W-1:0] DIGIT_RESET = 4'd0;
    localparam logic [RATE_W-1:0]  RATE_RESET  = 17'd8000;
    localparam logic [POWER_W-1:0] POWER_RESET = 7'd50;
    localparam logic [DUR_W-1:0]   DELAY_RESET = 24'd0;
    localparam logic [DUR_W-1:0]   TONE_RESET  = 24'd800;

    localparam logic [POWER_W-1:0] POWER_MAX   = 7'd100;

    // row (low) and column (high) frequency per key code
    localparam logic [HZ_W-1:0] ROW_HZ [16] = '{
        11'd941, 11'd697, 11'd697, 11'd697, 11'd770, 11'd770, 11'd770, 11'd852,
        11'd852, 11'd852, 11'd941, 11'd941, 11'd697, 11'd770, 11'd852, 11'd941
    };
    localparam logic [HZ_W-1:0] COL_HZ [16] = '{
        11'd1336, 11'd1209, 11'd1336, 11'd1477, 11'd1209, 11'd1336, 11'd1477, 11'd1209,
        11'd1336, 11'd1477, 11'd1209, 11'd1477, 11'd1633, 11'd1633, 11'd1633, 11'd1633
    };

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_sample;
        logic                       mix;
        logic                       tone_on;
        logic                       busy;
    } dtmf_item_t;

endpackage

### hdl/dtmf_arm.sv
`timescale 1ns / 1ps

module dtmf_arm
    import dtmf_pkg::*;
#(
    parameter int PHASE_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIGIT_W-1:0]    digit,
    input  logic [RATE_W-1:0]     sample_rate,
    input  logic [POWER_W-1:0]    power_percent,
    output logic [PHASE_BITS-1:0] low_step,
    output logic [PHASE_BITS-1:0] high_step,
    output logic [AMP_W-1:0]      amplitude,
    output logic                  ready
);

    localparam int NUM_W = PHASE_BITS + HZ_W;
    localparam int CNT_W = $clog2(NUM_W);

    localparam int AMP_WHOLE   = 327;
    localparam int AMP_FRAC    = 67;
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int AMP_FRAC_W  = 13;
    localparam int AMP_PROD_W  = 26;

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } arm_state_t;

    typedef enum logic {
        DIV_LOW,
        DIV_HIGH
    } div_sel_t;

    arm_state_t state_reg;
    div_sel_t   sel_reg;

    logic [NUM_W-1:0]  quo_reg;
    logic [RATE_W-1:0] rem_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic [PHASE_BITS-1:0] low_step_reg, high_step_reg;
    logic [AMP_W-1:0]      amplitude_reg;

    logic [POWER_W-1:0]    power_clamp;
    logic [AMP_FRAC_W-1:0] amp_frac;
    logic [AMP_PROD_W-1:0] amp_prod;
    logic [AMP_W-1:0]      amp_next;
    logic [NUM_W-1:0]      num_sel;
    logic [RATE_W:0]       trial, diff;
    logic                  ge;
    logic [RATE_W-1:0]     rem_next;
    logic [NUM_W-1:0]      quo_next;

    always_comb begin
        power_clamp = (power_percent > POWER_MAX) ? POWER_MAX : power_percent;
        // 0x7fff * p / 100 as 327 * p + (67 * p) / 100, the last by a reciprocal multiply
        amp_frac = AMP_FRAC_W'(power_clamp) * AMP_FRAC_W'(AMP_FRAC);
        amp_prod = AMP_PROD_W'(amp_frac) * AMP_PROD_W'(RECIP_100);
        amp_next = AMP_W'(power_clamp) * AMP_W'(AMP_WHOLE)
                 + AMP_W'(amp_prod[AMP_PROD_W-1:RECIP_SHIFT]);

        unique case (sel_reg)
            DIV_LOW: begin
                num_sel = {ROW_HZ[digit], {PHASE_BITS{1'b0}}};
            end
            DIV_HIGH: begin
                num_sel = {COL_HZ[digit], {PHASE_BITS{1'b0}}};
            end
        endcase

        // restoring division, one quotient bit per cycle; a zero divisor yields all ones
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        diff     = trial - {1'b0, sample_rate};
        ge       = trial >= {1'b0, sample_rate};
        rem_next = ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        amplitude_reg <= amp_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            sel_reg   <= DIV_LOW;
        end else if (start) begin
            state_reg <= ST_LOAD;
            sel_reg   <= DIV_LOW;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    quo_reg   <= num_sel;
                    rem_reg   <= '0;
                    cnt_reg   <= CNT_W'(NUM_W - 1);
                    state_reg <= ST_RUN;
                end
                ST_RUN: begin
                    quo_reg <= quo_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0) begin
                        unique case (sel_reg)
                            DIV_LOW: begin
                                low_step_reg <= quo_next[PHASE_BITS-1:0];
                                sel_reg      <= DIV_HIGH;
                                state_reg    <= ST_LOAD;
                            end
                            DIV_HIGH: begin
                                high_step_reg <= quo_next[PHASE_BITS-1:0];
                                state_reg     <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_DONE: begin
                    state_reg <= ST_DONE;
                end
                default: begin
                    state_reg <= ST_LOAD;
                    sel_reg   <= DIV_LOW;
                end
            endcase
        end
    end

    assign low_step  = low_step_reg;
    assign high_step = high_step_reg;
    assign amplitude = amplitude_reg;
    assign ready     = (state_reg == ST_DONE);

endmodule

### hdl/dtmf_sine.sv
`timescale 1ns / 1ps

module dtmf_sine
    import dtmf_pkg::*;
#(
    parameter int PHASE_BITS      = 16,
    parameter int SINE_TABLE_BITS = 8
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [PHASE_BITS-1:0]      phase_l,
    input  logic [PHASE_BITS-1:0]      phase_h,
    output logic signed [SAMPLE_W-1:0] sin_l,
    output logic signed [SAMPLE_W-1:0] sin_h
);

    localparam int TAB_N = 1 << SINE_TABLE_BITS;
    localparam int IDX_W = SINE_TABLE_BITS + 1;
    localparam int EXT_W = PHASE_BITS - 2 + SINE_TABLE_BITS;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [AMP_W-1:0] qtab_t [TAB_N+1];

    // sin(pi/2 * k / TAB_N) in q30 by taylor series to x^11, rounded to q15
    function automatic logic [AMP_W-1:0] quarter_entry(int unsigned k);
        logic [63:0] x, x2, term, sum, v;
        x    = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
        x2   = (x * x) >> 30;
        term = ((x * x2) >> 30) / 64'd6;
        sum  = x - term;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - term;
        v    = (sum + 64'd16384) >> 15;
        if (v > 64'h7fff) begin
            v = 64'h7fff;
        end
        return v[AMP_W-1:0];
    endfunction

    function automatic qtab_t build_quarter();
        qtab_t t;
        for (int k = 0; k <= TAB_N; k++) begin
            t[k] = quarter_entry(k);
        end
        return t;
    endfunction

    localparam qtab_t QUARTER = build_quarter();

    // fraction bits below the quadrant, truncated or zero padded to the table index
    function automatic logic [IDX_W-1:0] table_index(logic [PHASE_BITS-1:0] phase);
        logic [EXT_W-1:0]           ext;
        logic [SINE_TABLE_BITS-1:0] idx;
        ext = {phase[PHASE_BITS-3:0], {SINE_TABLE_BITS{1'b0}}};
        idx = ext[EXT_W-1:PHASE_BITS-2];
        if (phase[PHASE_BITS-2]) begin
            return IDX_W'(TAB_N) - {1'b0, idx};
        end
        return {1'b0, idx};
    endfunction

    logic [IDX_W-1:0]           idx_l, idx_h;
    logic [AMP_W-1:0]           mag_l, mag_h;
    logic signed [SAMPLE_W-1:0] sin_l_reg, sin_h_reg;

    always_comb begin
        idx_l = table_index(phase_l);
        idx_h = table_index(phase_h);
        mag_l = QUARTER[idx_l];
        mag_h = QUARTER[idx_h];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_l_reg <= phase_l[PHASE_BITS-1] ? -$signed({1'b0, mag_l}) : $signed({1'b0, mag_l});
            sin_h_reg <= phase_h[PHASE_BITS-1] ? -$signed({1'b0, mag_h}) : $signed({1'b0, mag_h});
        end
    end

    assign sin_l = sin_l_reg;
    assign sin_h = sin_h_reg;

endmodule

### hdl/dtmf_mixer.sv
`timescale 1ns / 1ps

module dtmf_mixer
    import dtmf_pkg::*;
(
    input  logic                       aclk,
    input  logic                       en,
    input  dtmf_item_t                 item_in,
    input  logic signed [SAMPLE_W-1:0] sin_l,
    input  logic signed [SAMPLE_W-1:0] sin_h,
    input  logic [AMP_W-1:0]           amplitude,
    output logic signed [SAMPLE_W-1:0] out_sample,
    output logic                       tone_on,
    output logic                       busy
);

    logic signed [SAMPLE_W:0]   sine_sum;
    logic signed [AMP_W:0]      amp_s;
    logic signed [32:0]         prod_full;
    logic signed [31:0]         prod_reg;
    dtmf_item_t                 item_reg;

    logic signed [33:0]         num, bias, adj;
    logic signed [SAMPLE_W-1:0] tone_val;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       tone_on_reg, busy_reg;

    always_comb begin
        sine_sum  = {sin_l[SAMPLE_W-1], sin_l} + {sin_h[SAMPLE_W-1], sin_h};
        amp_s     = $signed({1'b0, amplitude});
        prod_full = sine_sum * amp_s;
    end

    always_comb begin
        num = {{2{prod_reg[31]}}, prod_reg};
        if (item_reg.mix) begin
            num = num + {{2{item_reg.in_sample[SAMPLE_W-1]}}, item_reg.in_sample, 16'h0000};
        end
        // bias negative values so the shift truncates toward zero
        if (!num[33]) begin
            bias = '0;
        end else if (item_reg.mix) begin
            bias = 34'sh1ffff;
        end else begin
            bias = 34'sh0ffff;
        end
        adj      = num + bias;
        tone_val = item_reg.mix ? adj[32:17] : adj[31:16];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg       <= prod_full[31:0];
            item_reg       <= item_in;
            out_sample_reg <= item_reg.tone_on ? tone_val : item_reg.in_sample;
            tone_on_reg    <= item_reg.tone_on;
            busy_reg       <= item_reg.busy;
        end
    end

    assign out_sample = out_sample_reg;
    assign tone_on    = tone_on_reg;
    assign busy       = busy_reg;

endmodule

### hdl/dtmf_dual_tone_generator.sv
`timescale 1ns / 1ps

// DTMF tone generator on a sample stream. Every input item yields one result item
// through the item, mixer and output registers, and a new item is taken every cycle
// while the output is drained and no re-arm is running. Within the delay count the
// sample passes through; within the tone count the two keypad sines are summed,
// scaled by the power setting and either replace the sample or are averaged with it;
// afterwards samples pass through again. After reset and after every write to a known
// register the block re-arms: a shared restoring divider works out the two phase
// steps one quotient bit per cycle with s_tready low; the amplitude comes from a
// constant multiply on the power setting.
// Write configuration only while no items are in flight.
module dtmf_dual_tone_generator
    import dtmf_pkg::*;
#(
    parameter int PHASE_BITS      = 16,
    parameter int COUNT_BITS      = 24,
    parameter int SINE_TABLE_BITS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [SAMPLE_W-1:0]    s_tdata,   // [15:0] in_sample
    input  logic [0:0]             s_tuser,   // [0] mix

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [SAMPLE_W-1:0]    m_tdata,   // [15:0] out_sample
    output logic [1:0]             m_tuser,   // [0] tone_on, [1] busy_res

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [DIGIT_W-1:0] digit_reg, digit_next;
    logic [RATE_W-1:0]  sample_rate_reg, sample_rate_next;
    logic [POWER_W-1:0] power_reg, power_next;
    logic [DUR_W-1:0]   delay_samples_reg, delay_samples_next;
    logic [DUR_W-1:0]   tone_samples_reg, tone_samples_next;

    logic [COUNT_BITS-1:0] delay_left_reg, delay_left_next;
    logic [COUNT_BITS-1:0] tone_left_reg, tone_left_next;
    logic [PHASE_BITS-1:0] low_phase_reg, low_phase_next;
    logic [PHASE_BITS-1:0] high_phase_reg, high_phase_next;

    logic [PHASE_BITS-1:0] low_step, high_step;
    logic [AMP_W-1:0]      amplitude;
    logic                  arm_ready, arm_start;

    logic cfg_fire, s_fire, adv;
    logic tone_now, busy_now;

    dtmf_item_t item0_reg;
    logic       v0_reg, v1_reg, m_valid_reg;

    logic signed [SAMPLE_W-1:0] sin_l, sin_h, out_sample;
    logic                       tone_on, busy;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    // the whole pipeline moves when the output register is free or being taken
    assign adv       = !m_valid_reg || m_tready;
    assign s_tready  = arm_ready && adv;
    assign s_fire    = s_tvalid && s_tready;

    always_comb begin
        digit_next         = digit_reg;
        sample_rate_next   = sample_rate_reg;
        power_next         = power_reg;
        delay_samples_next = delay_samples_reg;
        tone_samples_next  = tone_samples_reg;
        arm_start          = 1'b0;
        if (cfg_fire) begin
            arm_start = 1'b1;
            unique case (cfg_index)
                CFG_DIGIT: digit_next         = cfg_data[DIGIT_W-1:0];
                CFG_RATE:  sample_rate_next   = cfg_data[RATE_W-1:0];
                CFG_POWER: power_next         = cfg_data[POWER_W-1:0];
                CFG_DELAY: delay_samples_next = cfg_data[DUR_W-1:0];
                CFG_TONE:  tone_samples_next  = cfg_data[DUR_W-1:0];
                default:   arm_start          = 1'b0;
            endcase
        end
    end

    always_comb begin
        delay_left_next = delay_left_reg;
        tone_left_next  = tone_left_reg;
        low_phase_next  = low_phase_reg;
        high_phase_next = high_phase_reg;
        tone_now        = (delay_left_reg == '0) && (tone_left_reg != '0);
        priority if (arm_start) begin
            delay_left_next = COUNT_BITS'(delay_samples_next);
            tone_left_next  = COUNT_BITS'(tone_samples_next);
            low_phase_next  = '0;
            high_phase_next = '0;
        end else if (s_fire) begin
            if (delay_left_reg != '0) begin
                delay_left_next = delay_left_reg - COUNT_BITS'(1);
            end else if (tone_now) begin
                tone_left_next  = tone_left_reg - COUNT_BITS'(1);
                low_phase_next  = low_phase_reg + low_step;
                high_phase_next = high_phase_reg + high_step;
            end
        end
        busy_now = (delay_left_next != '0) || (tone_left_next != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_reg         <= DIGIT_RESET;
            sample_rate_reg   <= RATE_RESET;
            power_reg         <= POWER_RESET;
            delay_samples_reg <= DELAY_RESET;
            tone_samples_reg  <= TONE_RESET;
            delay_left_reg    <= COUNT_BITS'(DELAY_RESET);
            tone_left_reg     <= COUNT_BITS'(TONE_RESET);
            low_phase_reg     <= '0;
            high_phase_reg    <= '0;
            v0_reg            <= 1'b0;
            v1_reg            <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            digit_reg         <= digit_next;
            sample_rate_reg   <= sample_rate_next;
            power_reg         <= power_next;
            delay_samples_reg <= delay_samples_next;
            tone_samples_reg  <= tone_samples_next;
            delay_left_reg    <= delay_left_next;
            tone_left_reg     <= tone_left_next;
            low_phase_reg     <= low_phase_next;
            high_phase_reg    <= high_phase_next;
            if (adv) begin
                v0_reg      <= s_fire;
                v1_reg      <= v0_reg;
                m_valid_reg <= v1_reg;
            end
        end
    end

    // sine lookup sees the phases before this item advances them
    always_ff @(posedge aclk) begin
        if (adv) begin
            item0_reg <= '{in_sample: s_tdata, mix: s_tuser[0], tone_on: tone_now,
                           busy: busy_now};
        end
    end

    dtmf_arm #(
        .PHASE_BITS(PHASE_BITS)
    ) u_arm (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (arm_start),
        .digit        (digit_reg),
        .sample_rate  (sample_rate_reg),
        .power_percent(power_reg),
        .low_step     (low_step),
        .high_step    (high_step),
        .amplitude    (amplitude),
        .ready        (arm_ready)
    );

    dtmf_sine #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_sine (
        .aclk   (aclk),
        .en     (adv),
        .phase_l(low_phase_reg),
        .phase_h(high_phase_reg),
        .sin_l  (sin_l),
        .sin_h  (sin_h)
    );

    dtmf_mixer u_mixer (
        .aclk      (aclk),
        .en        (adv),
        .item_in   (item0_reg),
        .sin_l     (sin_l),
        .sin_h     (sin_h),
        .amplitude (amplitude),
        .out_sample(out_sample),
        .tone_on   (tone_on),
        .busy      (busy)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_sample;
    assign m_tuser  = {busy, tone_on};

endmodule

### hdl/dtmf_checker.sv
`timescale 1ns / 1ps

module dtmf_checker
    import dtmf_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [SAMPLE_W-1:0]    m_tdata,
    input logic [1:0]             m_tuser,
    input logic                   cfg_valid,
    input logic                   cfg_ready,
    input logic [CFG_INDEX_W-1:0] cfg_index
);

    // reset leaves no result pending and starts arming
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("items accepted or shown right after reset");

    // a write to a known register re-arms the block
    a_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready && cfg_index <= CFG_TONE |=> !s_tready)
        else $error("input accepted while re-arming");

    // a stalled output stops the intake
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output stalled");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result item changed");

endmodule

bind dtmf_dual_tone_generator dtmf_checker u_dtmf_checker (.*);

### tb/dtmf_dual_tone_generator_test.sv
`timescale 1ns / 1ps

module dtmf_dual_tone_generator_test;
    import dtmf_pkg::*;

    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 40;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 4000;

    // no register lives at this index, a write there must not re-arm
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd6;

    typedef struct packed {
        logic [SAMPLE_W-1:0] smp;
        logic                on;
        logic                busy;
    } tone_result_t;

    class keypad_tone_tracker;
        int unsigned row_hz [16];
        int unsigned col_hz [16];
        int          quarter_sine [257];
        int unsigned digit, rate, power, delay_cfg, tone_cfg;
        int unsigned delay_left, tone_left, amplitude;
        bit [15:0]   low_phase, high_phase, low_step, high_step;
        tone_result_t expected_samples [$];
        int          mismatches;
        int          checked;
        int          tone_results;

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 60)
                $display("mismatch at %0t ns: %s", $time, what);
        endtask

        function void build_sine();
            longint unsigned x, x2, term, sum, v;
            for (int k = 0; k <= 256; k++) begin
                x = 64'd1686629713 * longint'(k) / 64'd256;
                x2 = (x * x) >> 30;
                term = x;
                sum = x;
                for (int n = 1; n <= 5; n++) begin
                    term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) sum -= term;
                    else sum += term;
                end
                v = (sum + 64'd16384) >> 15;
                if (v > 64'h7FFF) v = 64'h7FFF;
                quarter_sine[k] = int'(v);
            end
        endfunction

        function int sine_at(bit [15:0] ph);
            int unsigned idx;
            int v;
            idx = ph[13:6];
            if (ph[14]) idx = 256 - idx;
            v = quarter_sine[idx];
            return ph[15] ? -v : v;
        endfunction

        function bit [15:0] step_for(int unsigned hz);
            bit [63:0] q;
            if (rate == 0) return 16'hFFFF;
            q = (64'(hz) << 16) / 64'(rate);
            return q[15:0];
        endfunction

        function void arm();
            int unsigned p;
            p = (power > 100) ? 100 : power;
            low_step   = step_for(row_hz[digit]);
            high_step  = step_for(col_hz[digit]);
            low_phase  = '0;
            high_phase = '0;
            delay_left = delay_cfg;
            tone_left  = tone_cfg;
            amplitude  = (32767 * p) / 100;
        endfunction

        function void reset_state();
            row_hz = '{941, 697, 697, 697, 770, 770, 770, 852,
                       852, 852, 941, 941, 697, 770, 852, 941};
            col_hz = '{1336, 1209, 1336, 1477, 1209, 1336, 1477, 1209,
                       1336, 1477, 1209, 1477, 1633, 1633, 1633, 1633};
            build_sine();
            digit     = 0;
            rate      = 8000;
            power     = 50;
            delay_cfg = 0;
            tone_cfg  = 800;
            arm();
        endfunction

        function void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DIGIT: digit     = val[DIGIT_W-1:0];
                CFG_RATE:  rate      = val[RATE_W-1:0];
                CFG_POWER: power     = val[POWER_W-1:0];
                CFG_DELAY: delay_cfg = val[DUR_W-1:0];
                CFG_TONE:  tone_cfg  = val[DUR_W-1:0];
                default:   return;
            endcase
            arm();
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] raw, logic mx);
            longint s, t;
            int x, y;
            tone_result_t r;
            x = $signed(raw);
            y = x;
            r.on = 1'b0;
            if (delay_left != 0) begin
                delay_left--;
            end else if (tone_left != 0) begin
                s = longint'(sine_at(low_phase)) + longint'(sine_at(high_phase));
                t = s * longint'(amplitude);
                if (mx) y = int'((t + longint'(x) * 65536) / 131072);
                else y = int'(t / 65536);
                low_phase  += low_step;
                high_phase += high_step;
                tone_left--;
                r.on = 1'b1;
            end
            r.smp  = y[SAMPLE_W-1:0];
            r.busy = (delay_left != 0) || (tone_left != 0);
            expected_samples.push_back(r);
        endfunction

        task check_sample(logic [SAMPLE_W-1:0] data, logic [1:0] user);
            tone_result_t r;
            if (expected_samples.size() == 0) begin
                report_mismatch($sformatf("unexpected item out_sample %h", data));
                return;
            end
            r = expected_samples.pop_front();
            checked++;
            if (r.on) tone_results++;
            if (data !== r.smp)
                report_mismatch($sformatf("item %0d out_sample %h, want %h",
                                          checked, data, r.smp));
            if (user[0] !== r.on)
                report_mismatch($sformatf("item %0d tone_on %b, want %b",
                                          checked, user[0], r.on));
            if (user[1] !== r.busy)
                report_mismatch($sformatf("item %0d busy_res %b, want %b",
                                          checked, user[1], r.busy));
        endtask

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [SAMPLE_W-1:0]    s_tdata   = '0;
    logic [0:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [SAMPLE_W-1:0]    m_tdata;
    logic [1:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    keypad_tone_tracker tracker;
    int src_idle_pct = 12;
    int snk_idle_pct = 74;
    int samples_sent = 0;
    int reg_writes   = 0;
    int stall_cycles = 0;

    logic [SAMPLE_W-1:0] corner_samples [7] = '{
        16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA
    };

    dtmf_dual_tone_generator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // output side: check on handshake, then decide the next ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_sample(m_tdata, m_tuser);
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("dtmf_dual_tone_generator test failed");
            $finish;
        end
    end

    task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic mx);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= smp;
        s_tuser[0] <= mx;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        tracker.note_sample(smp, mx);
        samples_sent++;
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (cfg_ready !== 1'b1) @(posedge aclk);
        tracker.apply_reg(idx, val);
        reg_writes++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic configure_phase(input int ph);
        case (ph)
            1: begin
                // key code in the low nibble, junk above it
                write_reg(CFG_DIGIT, 24'h5A5A5B);
                write_reg(CFG_RATE,  24'd96000);
                write_reg(CFG_POWER, 24'd100);
                write_reg(CFG_DELAY, 24'd3);
                write_reg(CFG_TONE,  24'd20);
            end
            2: begin
                // power above 100, no tone at all
                write_reg(CFG_DIGIT, 24'd15);
                write_reg(CFG_RATE,  24'd1000);
                write_reg(CFG_POWER, 24'd127);
                write_reg(CFG_DELAY, 24'd0);
                write_reg(CFG_TONE,  24'd0);
            end
            3: begin
                // zero rate gives all-ones steps; zero power
                write_reg(CFG_DIGIT, 24'd10);
                write_reg(CFG_RATE,  24'd0);
                write_reg(CFG_POWER, 24'd0);
                write_reg(CFG_TONE,  24'd30);
            end
            4: begin
                // tiny rate: steps overflow the phase width
                write_reg(CFG_DIGIT, 24'd12);
                write_reg(CFG_RATE,  24'd3);
                write_reg(CFG_POWER, 24'd100);
                write_reg(CFG_TONE,  24'd60);
            end
            5: write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
            6: begin
                write_reg(CFG_RATE,  24'hFFFFFF);
                write_reg(CFG_POWER, 24'hFFFFFF);
                write_reg(CFG_DELAY, 24'hFFFFFF);
                write_reg(CFG_TONE,  24'hFFFFFF);
            end
            default: begin
                write_reg(CFG_DIGIT, CFG_DATA_W'($urandom_range(15)));
                write_reg(CFG_RATE,  ($urandom_range(3) == 0)
                                     ? CFG_DATA_W'($urandom_range(131071))
                                     : CFG_DATA_W'($urandom_range(96000, 1000)));
                write_reg(CFG_POWER, CFG_DATA_W'($urandom_range(127)));
                write_reg(CFG_DELAY, CFG_DATA_W'($urandom_range(8)));
                write_reg(CFG_TONE,  CFG_DATA_W'($urandom_range(60)));
            end
        endcase
        cfg_valid <= 1'b0;
    endtask

    initial begin
        tracker = new;
        tracker.reset_state();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // corner samples at the reset settings, both mix modes
        for (int mx = 0; mx < 2; mx++)
            foreach (corner_samples[i])
                push_sample(corner_samples[i], mx[0]);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph < 4) begin
                src_idle_pct = 12;
                snk_idle_pct = 74;
            end else if (ph < 7) begin
                src_idle_pct = 74;
                snk_idle_pct = 12;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            if (ph != 0) begin
                drain();
                configure_phase(ph);
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
                push_sample(pick_sample(), 1'($urandom_range(1)));
        end
        drain();

        $display("%0d samples over %0d settings, %0d register writes", samples_sent,
                 PHASES, reg_writes);
        $display("%0d results checked, %0d of them carried tone", tracker.checked,
                 tracker.tone_results);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("dtmf_dual_tone_generator test passed");
        else
            $display("dtmf_dual_tone_generator test failed");
        $finish;
    end

endmodule

### filelist.f
hdl/dtmf_pkg.sv
hdl/dtmf_arm.sv
hdl/dtmf_sine.sv
hdl/dtmf_mixer.sv
hdl/dtmf_dual_tone_generator.sv
hdl/dtmf_checker.sv
tb/dtmf_dual_tone_generator_test.sv
